[design/fso_pkg.sv]
// Shared constants, width helpers and status structs for the stochastic oscillator core.
package fso_pkg;

  // Default sizes
  localparam int PRICE_WIDTH_DEF  = 32;
  localparam int MAX_LOOKBACK_DEF = 64;
  localparam int MAX_SMOOTH_DEF   = 16;

  // Percent scale: hundredths of a percent
  localparam int PCT_W     = 14;
  localparam int PCT_SCALE = 10000;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int LB_CFG_W   = 7;
  localparam int SM_CFG_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KSMOOTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DSMOOTH  = 2'd2;

  localparam logic [LB_CFG_W-1:0] LB_RESET = 7'd14;
  localparam logic [SM_CFG_W-1:0] SM_RESET = 5'd3;

  // Depth of the front-to-back queue
  localparam int QUEUE_DEPTH = 2;

  // Width of a length that can hold 1..m
  function automatic int len_w(int m);
    return $clog2(m + 1);
  endfunction

  // Width of a running sum of up to m percent values
  function automatic int sum_w(int m);
    return $clog2(m * PCT_SCALE + 1);
  endfunction

  // Queue entry: restart, window valid, close, highest high, lowest low
  function automatic int ent_w(int pw);
    return 3 * pw + 2;
  endfunction

  typedef struct packed {
    logic full;
    logic empty;
  } fso_q_st_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } fso_div_st_t;

  typedef struct packed {
    logic done;
    logic full;
  } fso_ring_st_t;

endpackage

[design/fso_bar_if.sv]
// Price bar channel: valid/ready handshake with high, low, close and restart.
interface fso_bar_if import fso_pkg::*; #(
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH-1:0] bar_high;
  logic [PRICE_WIDTH-1:0] bar_low;
  logic [PRICE_WIDTH-1:0] bar_close;
  logic                   restart;

  modport source (output valid, output bar_high, output bar_low, output bar_close,
                  output restart, input ready);
  modport sink   (input valid, input bar_high, input bar_low, input bar_close,
                  input restart, output ready);
endinterface

[design/fso_res_if.sv]
// Result channel: valid/ready handshake with %K, smoothed %K, %D and flags.
interface fso_res_if import fso_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] raw_k;
  logic             raw_k_valid;
  logic [PCT_W-1:0] smooth_k;
  logic             smooth_k_valid;
  logic [PCT_W-1:0] smooth_d;
  logic             smooth_d_valid;
  logic             flat_range;

  modport source (output valid, output raw_k, output raw_k_valid, output smooth_k,
                  output smooth_k_valid, output smooth_d, output smooth_d_valid,
                  output flat_range, input ready);
  modport sink   (input valid, input raw_k, input raw_k_valid, input smooth_k,
                  input smooth_k_valid, input smooth_d, input smooth_d_valid,
                  input flat_range, output ready);
endinterface

[design/full_stochastic_oscillator_core.sv]
// Top level of the full stochastic oscillator (%K / %D) core.
// Each accepted bar yields exactly one result transaction. The front end takes a bar, writes it
// into the high/low window memories and, once the window is full, reads the window back one
// entry per cycle through the memory read port; it takes no new bar until its window extremes
// are pushed into the queue. A two-entry queue hands the window extremes to the back end, which
// runs up to three passes of one shared radix-2 divider (raw %K, smoothed %K, %D) plus
// sequencing states, with fewer passes during warm-up. Any configuration write to a defined
// register clears all history, like the restart bit; lengths of 0 act as 1 and lengths above
// the maximum act as the maximum. No clearing pass follows reset.
module full_stochastic_oscillator_core import fso_pkg::*; #(
  parameter int MAX_LOOKBACK = MAX_LOOKBACK_DEF,
  parameter int MAX_SMOOTH   = MAX_SMOOTH_DEF,
  parameter int PRICE_WIDTH  = PRICE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fso_bar_if.sink               in_bar,
  fso_res_if.source             out_res
);
  localparam int LB_W = len_w(MAX_LOOKBACK);
  localparam int SLW  = len_w(MAX_SMOOTH);
  localparam int EW   = ent_w(PRICE_WIDTH);
  localparam int LCW  = (LB_W > LB_CFG_W) ? LB_W : LB_CFG_W;
  localparam int SCW  = (SLW > SM_CFG_W) ? SLW : SM_CFG_W;

  logic [LB_CFG_W-1:0] lookback_r;
  logic [SM_CFG_W-1:0] ksm_r;
  logic [SM_CFG_W-1:0] dsm_r;

  logic                hist_clr;
  logic [LB_W-1:0]     lb_eff;
  logic [SLW-1:0]      kl_eff;
  logic [SLW-1:0]      dl_eff;

  logic                q_push;
  logic                q_pop;
  logic [EW-1:0]       q_wdata;
  logic [EW-1:0]       q_rdata;
  fso_q_st_t           q_st;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookback_r <= LB_RESET;
      ksm_r      <= SM_RESET;
      dsm_r      <= SM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOOKBACK: lookback_r <= cfg_data[LB_CFG_W-1:0];
        CFG_KSMOOTH:  ksm_r      <= cfg_data[SM_CFG_W-1:0];
        CFG_DSMOOTH:  dsm_r      <= cfg_data[SM_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign hist_clr = cfg_we && (cfg_index == CFG_LOOKBACK || cfg_index == CFG_KSMOOTH ||
                               cfg_index == CFG_DSMOOTH);

  // Effective lengths: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (lookback_r == '0) begin
      lb_eff = LB_W'(1);
    end else if (LCW'(lookback_r) > LCW'(MAX_LOOKBACK)) begin
      lb_eff = LB_W'(MAX_LOOKBACK);
    end else begin
      lb_eff = LB_W'(lookback_r);
    end
    if (ksm_r == '0) begin
      kl_eff = SLW'(1);
    end else if (SCW'(ksm_r) > SCW'(MAX_SMOOTH)) begin
      kl_eff = SLW'(MAX_SMOOTH);
    end else begin
      kl_eff = SLW'(ksm_r);
    end
    if (dsm_r == '0) begin
      dl_eff = SLW'(1);
    end else if (SCW'(dsm_r) > SCW'(MAX_SMOOTH)) begin
      dl_eff = SLW'(MAX_SMOOTH);
    end else begin
      dl_eff = SLW'(dsm_r);
    end
  end

  fso_front #(
    .PRICE_WIDTH  (PRICE_WIDTH),
    .MAX_LOOKBACK (MAX_LOOKBACK)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .hist_clr (hist_clr),
    .lb_len   (lb_eff),
    .in_bar   (in_bar),
    .q_st     (q_st),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  fso_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .st    (q_st)
  );

  fso_back #(
    .PRICE_WIDTH (PRICE_WIDTH),
    .MAX_SMOOTH  (MAX_SMOOTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .hist_clr (hist_clr),
    .k_len    (kl_eff),
    .d_len    (dl_eff),
    .q_data   (q_rdata),
    .q_st     (q_st),
    .q_pop    (q_pop),
    .out_res  (out_res)
  );

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_st.full)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_st.empty)
    else $error("queue popped while empty");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bar.valid && in_bar.ready) |=> !in_bar.ready)
    else $error("front end took a bar while still working on one");

  a_flag_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> ((!out_res.smooth_d_valid || out_res.smooth_k_valid) &&
                       (!out_res.smooth_k_valid || out_res.raw_k_valid) &&
                       (!out_res.flat_range || out_res.raw_k_valid)))
    else $error("result valid flags out of order");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.raw_k <= PCT_W'(PCT_SCALE) &&
                       out_res.smooth_k <= PCT_W'(PCT_SCALE) &&
                       out_res.smooth_d <= PCT_W'(PCT_SCALE)))
    else $error("percent value above full scale");

endmodule

[design/fso_front.sv]
// Front end: takes bars, keeps the high/low window memories and scans for the extremes.
module fso_front import fso_pkg::*; #(
  parameter int PRICE_WIDTH  = PRICE_WIDTH_DEF,
  parameter int MAX_LOOKBACK = MAX_LOOKBACK_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               hist_clr,
  input  logic [len_w(MAX_LOOKBACK)-1:0]     lb_len,
  fso_bar_if.sink                            in_bar,
  input  fso_q_st_t                          q_st,
  output logic                               q_push,
  output logic [ent_w(PRICE_WIDTH)-1:0]      q_data
);
  localparam int PW   = PRICE_WIDTH;
  localparam int LB_W = len_w(MAX_LOOKBACK);
  localparam int AW   = $clog2(MAX_LOOKBACK);

  typedef enum logic [1:0] {F_IDLE, F_SCAN, F_PUSH} f_state_t;

  f_state_t        state_r;
  logic [AW-1:0]   head_r;
  logic [LB_W-1:0] seen_r;
  logic [AW-1:0]   rd_addr_r;
  logic [LB_W-1:0] issue_cnt_r;
  logic            rd_vld_r;
  logic            rd_last_r;
  logic [PW-1:0]   rd_high_r;
  logic [PW-1:0]   rd_low_r;
  logic [PW-1:0]   hh_r;
  logic [PW-1:0]   ll_r;
  logic [PW-1:0]   close_r;
  logic            rst_r;
  logic            rv_r;

  logic [PW-1:0]   high_mem [MAX_LOOKBACK];
  logic [PW-1:0]   low_mem  [MAX_LOOKBACK];

  logic            accept;
  logic [AW-1:0]   head_use;
  logic [AW-1:0]   head_inc;
  logic [LB_W-1:0] seen_base;
  logic [LB_W-1:0] seen_new;
  logic            rv_new;
  logic            issue;
  logic [AW-1:0]   rd_addr_dec;
  logic [PW-1:0]   hh_cmp;
  logic [PW-1:0]   ll_cmp;

  assign in_bar.ready = (state_r == F_IDLE);
  assign accept       = in_bar.valid && in_bar.ready;

  // Restart writes the bar as the first of a fresh window
  always_comb begin
    head_use  = in_bar.restart ? '0 : head_r;
    seen_base = in_bar.restart ? '0 : seen_r;
    head_inc  = (head_use == AW'(MAX_LOOKBACK - 1)) ? '0 : head_use + AW'(1);
    seen_new  = (seen_base == LB_W'(MAX_LOOKBACK)) ? seen_base : seen_base + LB_W'(1);
    rv_new    = (seen_new >= lb_len);
  end

  assign issue       = (state_r == F_SCAN) && (issue_cnt_r != lb_len);
  assign rd_addr_dec = (rd_addr_r == '0) ? AW'(MAX_LOOKBACK - 1) : rd_addr_r - AW'(1);
  assign hh_cmp      = (rd_high_r > hh_r) ? rd_high_r : hh_r;
  assign ll_cmp      = (rd_low_r < ll_r) ? rd_low_r : ll_r;

  // Window memories: one write on accept, one registered read per scan cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      high_mem[head_use] <= in_bar.bar_high;
      low_mem[head_use]  <= in_bar.bar_low;
    end
    if (issue) begin
      rd_high_r <= high_mem[rd_addr_r];
      rd_low_r  <= low_mem[rd_addr_r];
    end
  end

  // Sequencer: accept, scan newest to oldest, hand over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      head_r   <= '0;
      seen_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (hist_clr) begin
        head_r <= '0;
        seen_r <= '0;
      end
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            head_r      <= head_inc;
            seen_r      <= seen_new;
            close_r     <= in_bar.bar_close;
            rst_r       <= in_bar.restart;
            rv_r        <= rv_new;
            rd_addr_r   <= head_use;
            issue_cnt_r <= '0;
            hh_r        <= '0;
            ll_r        <= '1;
            rd_vld_r    <= 1'b0;
            state_r     <= rv_new ? F_SCAN : F_PUSH;
          end
        end
        F_SCAN: begin
          rd_vld_r  <= issue;
          rd_last_r <= (issue_cnt_r == lb_len - LB_W'(1));
          if (issue) begin
            rd_addr_r   <= rd_addr_dec;
            issue_cnt_r <= issue_cnt_r + LB_W'(1);
          end
          if (rd_vld_r) begin
            hh_r <= hh_cmp;
            ll_r <= ll_cmp;
            if (rd_last_r) begin
              state_r <= F_PUSH;
            end
          end
        end
        F_PUSH: begin
          if (!q_st.full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

  assign q_push = (state_r == F_PUSH) && !q_st.full;
  assign q_data = {rst_r, rv_r, close_r, hh_r, ll_r};

endmodule

[design/fso_queue.sv]
// Short FIFO between the front end and the back end.
module fso_queue import fso_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output fso_q_st_t        st
);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   cnt_r;

  function automatic logic [QAW-1:0] ptr_inc(logic [QAW-1:0] p);
    return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

  assign rdata    = slot[rd_ptr_r];
  assign st.full  = (cnt_r == QCW'(QUEUE_DEPTH));
  assign st.empty = (cnt_r == '0);

endmodule

[design/fso_div.sv]
// Shared restoring divider: 14 quotient bits, one bit per cycle.
module fso_div import fso_pkg::*; #(
  parameter int DVS_W = PRICE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DVS_W+PCT_W-1:0]   dividend,
  input  logic [DVS_W-1:0]         divisor,
  output fso_div_st_t              st
);
  // Caller guarantees dividend < divisor * 2^PCT_W
  localparam int DVD_W = DVS_W + PCT_W;
  localparam int CNT_W = $clog2(PCT_W + 1);

  logic [DVS_W-1:0] rem_r;
  logic [PCT_W-1:0] lo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, lo_r[PCT_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= dividend[DVD_W-1:PCT_W];
        lo_r  <= dividend[PCT_W-1:0];
        dvs_r <= divisor;
        cnt_r <= CNT_W'(PCT_W);
      end else if (cnt_r != '0) begin
        rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        lo_r  <= {lo_r[PCT_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign st.done = done_r;
  assign st.quot = lo_r;

endmodule

[design/fso_ring.sv]
// Moving-average ring: stores recent values and keeps a running window sum.
module fso_ring import fso_pkg::*; #(
  parameter int MAX_SMOOTH = MAX_SMOOTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic                          start,
  input  logic [PCT_W-1:0]              val,
  input  logic [len_w(MAX_SMOOTH)-1:0]  len,
  output fso_ring_st_t                  st,
  output logic [sum_w(MAX_SMOOTH)-1:0]  sum
);
  localparam int SLW = len_w(MAX_SMOOTH);
  localparam int SW  = sum_w(MAX_SMOOTH);
  localparam int SIW = (MAX_SMOOTH > 1) ? $clog2(MAX_SMOOTH) : 1;

  logic [PCT_W-1:0] mem [MAX_SMOOTH];
  logic [SIW-1:0]   head_r;
  logic [SLW-1:0]   count_r;
  logic [SW-1:0]    sum_r;
  logic             busy_r;
  logic [PCT_W-1:0] val_r;
  logic [PCT_W-1:0] old_r;
  logic             drop_r;
  logic             done_r;
  logic             full_r;

  logic [SIW:0]     base;
  logic [SIW-1:0]   rd_idx;
  logic [SIW-1:0]   head_inc;
  logic [SLW-1:0]   count_inc;
  logic [SW:0]      acc;

  // Oldest entry of the window leaves when the window is already full
  always_comb begin
    base      = {1'b0, head_r} + (SIW+1)'(MAX_SMOOTH) - (SIW+1)'(len);
    rd_idx    = (base >= (SIW+1)'(MAX_SMOOTH)) ? SIW'(base - (SIW+1)'(MAX_SMOOTH))
                                              : base[SIW-1:0];
    head_inc  = (head_r == SIW'(MAX_SMOOTH - 1)) ? '0 : head_r + SIW'(1);
    count_inc = (count_r == SLW'(MAX_SMOOTH)) ? count_r : count_r + SLW'(1);
    acc       = {1'b0, sum_r} + (SW+1)'(val_r) - (drop_r ? (SW+1)'(old_r) : '0);
  end

  // Store: read the leaving entry on start, write the new one in the cycle after
  always_ff @(posedge clk) begin
    if (start) begin
      old_r <= mem[rd_idx];
    end
    if (busy_r) begin
      mem[head_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (clr) begin
        head_r  <= '0;
        count_r <= '0;
        sum_r   <= '0;
        busy_r  <= 1'b0;
      end else if (start) begin
        val_r  <= val;
        drop_r <= (count_r >= len);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        busy_r  <= 1'b0;
        sum_r   <= acc[SW-1:0];
        head_r  <= head_inc;
        count_r <= count_inc;
        done_r  <= 1'b1;
        full_r  <= (count_inc >= len);
      end
    end
  end

  assign st.done = done_r;
  assign st.full = full_r;
  assign sum     = sum_r;

endmodule

[design/fso_back.sv]
// Back end: raw %K ratio, two moving averages on a shared divider, result register.
module fso_back import fso_pkg::*; #(
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
  parameter int MAX_SMOOTH  = MAX_SMOOTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              hist_clr,
  input  logic [len_w(MAX_SMOOTH)-1:0]      k_len,
  input  logic [len_w(MAX_SMOOTH)-1:0]      d_len,
  input  logic [ent_w(PRICE_WIDTH)-1:0]     q_data,
  input  fso_q_st_t                         q_st,
  output logic                              q_pop,
  fso_res_if.source                         out_res
);
  localparam int PW    = PRICE_WIDTH;
  localparam int EW    = ent_w(PRICE_WIDTH);
  localparam int SLW   = len_w(MAX_SMOOTH);
  localparam int SW    = sum_w(MAX_SMOOTH);
  localparam int DVD_W = PW + PCT_W;

  typedef enum logic [3:0] {
    B_IDLE, B_CLASS, B_MUL, B_RDIV, B_KSTART, B_KWAIT, B_KDIV,
    B_DSTART, B_DWAIT, B_DDIV, B_EMIT
  } b_state_t;

  b_state_t         state_r;
  logic             rv_r;
  logic [PW-1:0]    close_r;
  logic [PW-1:0]    hh_r;
  logic [PW-1:0]    ll_r;
  logic [PW-1:0]    num_r;
  logic [PW-1:0]    den_r;
  logic [PCT_W-1:0] raw_r;
  logic [PCT_W-1:0] sk_r;
  logic [PCT_W-1:0] sd_r;
  logic             kv_r;
  logic             dv_r;
  logic             flat_r;

  logic             ov_r;
  logic [PCT_W-1:0] raw_k_r;
  logic             raw_k_valid_r;
  logic [PCT_W-1:0] smooth_k_r;
  logic             smooth_k_valid_r;
  logic [PCT_W-1:0] smooth_d_r;
  logic             smooth_d_valid_r;
  logic             flat_range_r;

  logic             ring_clr;
  logic             rk_start;
  logic             rd_start;
  fso_ring_st_t     rk_st;
  fso_ring_st_t     rd_st;
  logic [SW-1:0]    sum_k;
  logic [SW-1:0]    sum_d;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [PW-1:0]    div_dvs;
  fso_div_st_t      div_st;

  // Restart of a bar clears the averages as it leaves the queue
  assign q_pop    = (state_r == B_IDLE) && !q_st.empty;
  assign ring_clr = hist_clr || (q_pop && q_data[EW-1]);
  assign rk_start = (state_r == B_KSTART);
  assign rd_start = (state_r == B_DSTART);

  // Divider operand select: price ratio or one of the two averages
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_r)
      B_MUL: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(num_r) * DVD_W'(PCT_SCALE);
        div_dvs   = den_r;
      end
      B_KWAIT: begin
        div_start = rk_st.done && rk_st.full;
        div_dvd   = {{(DVD_W-SW){1'b0}}, sum_k};
        div_dvs   = {{(PW-SLW){1'b0}}, k_len};
      end
      B_DWAIT: begin
        div_start = rd_st.done && rd_st.full;
        div_dvd   = {{(DVD_W-SW){1'b0}}, sum_d};
        div_dvs   = {{(PW-SLW){1'b0}}, d_len};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  fso_div #(
    .DVS_W (PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .st       (div_st)
  );

  fso_ring #(
    .MAX_SMOOTH (MAX_SMOOTH)
  ) u_ring_k (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ring_clr),
    .start (rk_start),
    .val   (raw_r),
    .len   (k_len),
    .st    (rk_st),
    .sum   (sum_k)
  );

  fso_ring #(
    .MAX_SMOOTH (MAX_SMOOTH)
  ) u_ring_d (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ring_clr),
    .start (rd_start),
    .val   (sk_r),
    .len   (d_len),
    .st    (rd_st),
    .sum   (sum_d)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && out_res.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_st.empty) begin
            rv_r    <= q_data[EW-2];
            close_r <= q_data[3*PW-1:2*PW];
            hh_r    <= q_data[2*PW-1:PW];
            ll_r    <= q_data[PW-1:0];
            raw_r   <= '0;
            sk_r    <= '0;
            sd_r    <= '0;
            kv_r    <= 1'b0;
            dv_r    <= 1'b0;
            flat_r  <= 1'b0;
            state_r <= B_CLASS;
          end
        end
        B_CLASS: begin
          if (!rv_r) begin
            state_r <= B_EMIT;
          end else if (hh_r <= ll_r) begin
            // flat or inverted window
            flat_r  <= 1'b1;
            state_r <= B_KSTART;
          end else if (close_r <= ll_r) begin
            state_r <= B_KSTART;
          end else if (close_r >= hh_r) begin
            raw_r   <= PCT_W'(PCT_SCALE);
            state_r <= B_KSTART;
          end else begin
            num_r   <= close_r - ll_r;
            den_r   <= hh_r - ll_r;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          state_r <= B_RDIV;
        end
        B_RDIV: begin
          if (div_st.done) begin
            raw_r   <= div_st.quot;
            state_r <= B_KSTART;
          end
        end
        B_KSTART: begin
          state_r <= B_KWAIT;
        end
        B_KWAIT: begin
          if (rk_st.done) begin
            if (rk_st.full) begin
              kv_r    <= 1'b1;
              state_r <= B_KDIV;
            end else begin
              state_r <= B_EMIT;
            end
          end
        end
        B_KDIV: begin
          if (div_st.done) begin
            sk_r    <= div_st.quot;
            state_r <= B_DSTART;
          end
        end
        B_DSTART: begin
          state_r <= B_DWAIT;
        end
        B_DWAIT: begin
          if (rd_st.done) begin
            if (rd_st.full) begin
              dv_r    <= 1'b1;
              state_r <= B_DDIV;
            end else begin
              state_r <= B_EMIT;
            end
          end
        end
        B_DDIV: begin
          if (div_st.done) begin
            sd_r    <= div_st.quot;
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!ov_r || out_res.ready) begin
            ov_r             <= 1'b1;
            raw_k_r          <= raw_r;
            raw_k_valid_r    <= rv_r;
            smooth_k_r       <= sk_r;
            smooth_k_valid_r <= kv_r;
            smooth_d_r       <= sd_r;
            smooth_d_valid_r <= dv_r;
            flat_range_r     <= flat_r;
            state_r          <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid          = ov_r;
  assign out_res.raw_k          = raw_k_r;
  assign out_res.raw_k_valid    = raw_k_valid_r;
  assign out_res.smooth_k       = smooth_k_r;
  assign out_res.smooth_k_valid = smooth_k_valid_r;
  assign out_res.smooth_d       = smooth_d_r;
  assign out_res.smooth_d_valid = smooth_d_valid_r;
  assign out_res.flat_range     = flat_range_r;

endmodule
